>>> src/bsm_pkg.sv
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int OPERAND_W = 32;
    localparam int PRODUCT_W = 64;

    // booth recoding width, 4 to 32
    localparam int WIDTH = 32;
    localparam int ACC_W = WIDTH + 1;

    typedef logic [OPERAND_W-1:0] operand_t;
    typedef logic [PRODUCT_W-1:0] product_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [WIDTH-1:0] q;
        logic             prev;
        logic [ACC_W-1:0] mcand;
    } bsm_step_t;

    typedef enum logic [1:0] {
        BOOTH_NOP_LO = 2'b00,
        BOOTH_ADD    = 2'b01,
        BOOTH_SUB    = 2'b10,
        BOOTH_NOP_HI = 2'b11
    } booth_op_t;

endpackage

>>> src/bsm_in_if.sv
`timescale 1ns / 1ps

interface bsm_in_if
    import bsm_pkg::*;
();

    logic     valid;
    logic     ready;
    operand_t multiplicand;
    operand_t multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink (input valid, input multiplicand, input multiplier, output ready);

endinterface

>>> src/bsm_out_if.sv
`timescale 1ns / 1ps

interface bsm_out_if
    import bsm_pkg::*;
();

    logic     valid;
    logic     ready;
    product_t product;

    modport source (output valid, output product, input ready);
    modport sink (input valid, input product, output ready);

endinterface

>>> src/booth_signed_multiplier.sv
`timescale 1ns / 1ps
// an operand transfer passes every pipeline stage before its product is valid
// throughput: one transfer per cycle unless the result is stalled, one booth step per pipeline stage
// a stalled result freezes the whole pipeline until it is taken
// reset: asynchronous, active low, clears all stage valid bits
// no state survives between items

module booth_signed_multiplier
    import bsm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    bsm_in_if.sink   operands,
    bsm_out_if.source result
);

    logic                     en;
    logic      [WIDTH-1:0]    stage_valid;
    bsm_step_t                stage_data [WIDTH];
    bsm_step_t                init;
    logic signed [WIDTH-1:0]  mc_in;
    logic signed [2*WIDTH-1:0] prod_raw;
    bsm_step_t                last;

    assign en             = !result.valid || result.ready;
    assign operands.ready = en;

    assign mc_in      = operands.multiplicand[WIDTH-1:0];
    assign init.acc   = '0;
    assign init.q     = operands.multiplier[WIDTH-1:0];
    assign init.prev  = 1'b0;
    assign init.mcand = ACC_W'(mc_in);

    genvar i;
    generate
        for (i = 0; i < WIDTH; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                bsm_stage u_stage (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .in_valid  (operands.valid),
                    .in_data   (init),
                    .out_valid (stage_valid[i]),
                    .out_data  (stage_data[i])
                );
            end
            else
            begin : g_next
                bsm_stage u_stage (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .in_valid  (stage_valid[i-1]),
                    .in_data   (stage_data[i-1]),
                    .out_valid (stage_valid[i]),
                    .out_data  (stage_data[i])
                );
            end
        end
    endgenerate

    assign last     = stage_data[WIDTH-1];
    assign prod_raw = {last.acc[WIDTH-1:0], last.q};

    assign result.valid   = stage_valid[WIDTH-1];
    assign result.product = PRODUCT_W'(prod_raw);

    // a stalled pipeline holds every valid bit
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_valid))
        else $error("pipeline valid bits moved during stall");

    // a new result comes only from the stage before the output
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(stage_valid[WIDTH-2]))
        else $error("result valid without upstream item");

    // an accepted operand pair enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |=> stage_valid[0])
        else $error("accepted operands lost at pipeline entry");

endmodule

>>> src/bsm_stage.sv
`timescale 1ns / 1ps

module bsm_stage
    import bsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  bsm_step_t in_data,
    output logic      out_valid,
    output bsm_step_t out_data
);

    logic             valid_reg;
    bsm_step_t        data_reg;
    bsm_step_t        data_next;
    logic [ACC_W-1:0] sum;
    booth_op_t        op;

    assign op = booth_op_t'({in_data.q[0], in_data.prev});

    always_comb
    begin
        unique case (op)
            BOOTH_SUB: sum = in_data.acc - in_data.mcand;
            BOOTH_ADD: sum = in_data.acc + in_data.mcand;
            default:   sum = in_data.acc;
        endcase
    end

    // arithmetic shift of acc:q, guard bit kept
    always_comb
    begin
        data_next.acc   = {sum[ACC_W-1], sum[ACC_W-1:1]};
        data_next.q     = {sum[0], in_data.q[WIDTH-1:1]};
        data_next.prev  = in_data.q[0];
        data_next.mcand = in_data.mcand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> tb/booth_signed_multiplier_tb.sv
`timescale 1ns / 1ps

module booth_signed_multiplier_tb;

    import bsm_pkg::*;

    localparam int          RANDOM_JOBS = 1650;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct {
        operand_t multiplicand;
        operand_t multiplier;
        logic     drain_first;
    } mul_job_t;

    logic clk;
    logic rst_n;

    bsm_in_if  operands_if ();
    bsm_out_if result_if ();

    booth_signed_multiplier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .result   (result_if)
    );

    mul_job_t    pending_jobs[$];
    product_t    expected_products[$];
    int          in_flight;
    int          mismatches;
    int unsigned cycle_count;
    int unsigned send_gap;
    int unsigned take_stall;
    logic        send_calm;
    logic        take_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // booth radix-2 recoding over WIDTH bits with a guard bit on the accumulator
    function automatic product_t booth_product(operand_t a, operand_t b);
        logic [ACC_W-1:0]          mc;
        logic [ACC_W-1:0]          mc_neg;
        logic [ACC_W-1:0]          acc;
        logic [WIDTH-1:0]          q;
        logic                      prev;
        booth_op_t                 op;
        logic signed [2*WIDTH-1:0] full;
        product_t                  res;
        mc     = {a[WIDTH-1], a[WIDTH-1:0]};
        mc_neg = '0 - mc;
        acc    = '0;
        q      = b[WIDTH-1:0];
        prev   = 1'b0;
        for (int i = 0; i < WIDTH; i++)
        begin
            op = booth_op_t'({q[0], prev});
            case (op)
                BOOTH_SUB: acc = acc + mc_neg;
                BOOTH_ADD: acc = acc + mc;
                default:   acc = acc;
            endcase
            prev = q[0];
            q    = {acc[0], q[WIDTH-1:1]};
            acc  = {acc[ACC_W-1], acc[ACC_W-1:1]};
        end
        full = {acc[WIDTH-1:0], q};
        res  = full;
        return res;
    endfunction

    function automatic int unsigned pick_idle(logic calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic operand_t pick_operand();
        operand_t          v;
        logic [63:0]       run;
        int unsigned       lo;
        int unsigned       hi;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: v = '0;
                    1: v = operand_t'(1);
                    2: v = '1;
                    3: v = operand_t'(1) << (WIDTH - 1);
                    4: v = (operand_t'(1) << (WIDTH - 1)) - 1;
                    default: v = operand_t'(1) << (WIDTH - 1) | operand_t'(1);
                endcase
            end
            1: v = operand_t'(1) << $urandom_range(0, OPERAND_W - 1);
            2: v = '0 - (operand_t'(1) << $urandom_range(0, OPERAND_W - 1));
            3: v = operand_t'($urandom_range(0, 63)) - operand_t'(32);
            4:
            begin
                lo  = $urandom_range(0, OPERAND_W - 1);
                hi  = $urandom_range(lo, OPERAND_W);
                run = ((64'd1 << hi) - 1) ^ ((64'd1 << lo) - 1);
                v   = operand_t'(run) ^ ($urandom_range(0, 3) == 0 ? operand_t'($urandom) : '0);
            end
            5: v = $urandom_range(0, 1) ? operand_t'(32'h5555_5555) : operand_t'(32'hAAAA_AAAA);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_job(operand_t a, operand_t b, logic drain_first);
        mul_job_t job;
        job.multiplicand = a;
        job.multiplier   = b;
        job.drain_first  = drain_first;
        pending_jobs.push_back(job);
    endtask

    task automatic report_mismatch(string what, product_t got, product_t want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // operand side
    always @(posedge clk or negedge rst_n)
    begin : operand_driver
        mul_job_t job;
        logic     busy;
        if (!rst_n)
        begin
            operands_if.valid        <= 1'b0;
            operands_if.multiplicand <= '0;
            operands_if.multiplier   <= '0;
            send_gap                 <= 0;
        end
        else if (!operands_if.valid || operands_if.ready)
        begin
            busy = (in_flight != 0) || operands_if.valid;
            if (send_gap != 0)
            begin
                send_gap          <= send_gap - 1;
                operands_if.valid <= 1'b0;
            end
            else if (pending_jobs.size() != 0 && !(pending_jobs[0].drain_first && busy))
            begin
                job = pending_jobs.pop_front();
                operands_if.multiplicand <= job.multiplicand;
                operands_if.multiplier   <= job.multiplier;
                operands_if.valid        <= 1'b1;
                send_gap                 <= pick_idle(send_calm);
            end
            else
            begin
                operands_if.valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            take_stall      <= 0;
        end
        else if (take_stall != 0)
        begin
            take_stall      <= take_stall - 1;
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
            take_stall      <= pick_idle(take_calm);
        end
    end

    // checks products and tracks transfers in flight
    always @(posedge clk or negedge rst_n)
    begin : product_monitor
        product_t want;
        int       delta;
        if (!rst_n)
        begin
            in_flight <= 0;
        end
        else
        begin
            delta = 0;
            if (result_if.valid && result_if.ready)
            begin
                if (expected_products.size() == 0)
                begin
                    report_mismatch("unexpected product", result_if.product, '0);
                end
                else
                begin
                    want = expected_products.pop_front();
                    delta--;
                    if (result_if.product !== want)
                        report_mismatch("product", result_if.product, want);
                end
            end
            if (operands_if.valid && operands_if.ready)
            begin
                expected_products.push_back(
                    booth_product(operands_if.multiplicand, operands_if.multiplier));
                delta++;
            end
            in_flight <= in_flight + delta;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0)
        begin
            send_calm <= ($urandom_range(0, 3) == 0);
            take_calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        operand_t most_neg;
        operand_t most_pos;
        rst_n                    = 1'b0;
        operands_if.valid        = 1'b0;
        operands_if.multiplicand = '0;
        operands_if.multiplier   = '0;
        result_if.ready          = 1'b0;
        mismatches               = 0;
        cycle_count              = 0;
        send_calm                = 1'b0;
        take_calm                = 1'b0;

        most_neg = operand_t'(1) << (WIDTH - 1);
        most_pos = most_neg - 1;

        add_job('0, '0, 1'b0);
        add_job(operand_t'(1), operand_t'(1), 1'b0);
        add_job('1, '1, 1'b0);
        add_job(most_neg, most_neg, 1'b0);
        add_job(most_neg, most_pos, 1'b0);
        add_job(most_pos, most_neg, 1'b0);
        add_job(most_pos, most_pos, 1'b0);
        add_job(most_neg, '1, 1'b0);
        add_job('1, most_neg, 1'b0);
        add_job(most_neg, operand_t'(1), 1'b0);
        add_job(operand_t'(1), most_neg, 1'b0);
        add_job('0, most_neg, 1'b0);
        add_job(most_neg, '0, 1'b1);
        add_job(operand_t'(32'h5555_5555), operand_t'(32'hAAAA_AAAA), 1'b0);
        add_job(operand_t'(32'hAAAA_AAAA), operand_t'(32'h5555_5555), 1'b0);
        add_job(operand_t'(7), '0 - operand_t'(3), 1'b0);
        add_job('0 - operand_t'(7), operand_t'(3), 1'b0);
        add_job(most_pos, '1, 1'b0);
        add_job(operand_t'(32'h0000_FFFF), operand_t'(32'hFFFF_0000), 1'b0);
        add_job(operand_t'(32'h7FFF_0001), operand_t'(32'h8000_FFFF), 1'b1);
        for (int i = 0; i < RANDOM_JOBS; i++)
            add_job(pick_operand(), pick_operand(), $urandom_range(0, 149) == 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_jobs.size() != 0 || operands_if.valid || in_flight != 0)
            @(posedge clk);
        repeat (WIDTH + 16) @(posedge clk);

        if (expected_products.size() != 0)
            report_mismatch("missing product", '0, expected_products[0]);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
